// ===== rtl/core/twcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcs_pkg
// Shared types and constants of the textured wall column sampler.
// ----------------------------------------------------------------------------
package twcs_pkg;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_H = 2'd0,
		REG_FRAME_W = 2'd1,
		REG_TEX_W   = 2'd2,
		REG_TEX_H   = 2'd3
	} cfg_reg_t;

	localparam logic [11:0] FRAME_H_RST = 12'd480;
	localparam logic [12:0] FRAME_W_RST = 13'd640;
	localparam logic [6:0]  TEX_W_RST   = 7'd64;
	localparam logic [6:0]  TEX_H_RST   = 7'd64;

	// transaction kinds
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_DRAW  = 1'b1;

	// texture row divider: numerator (row offset * tex height), span length, quotient
	localparam int NUM_W = 18;
	localparam int DEN_W = 13;
	localparam int QW    = 7;

	// colors and side shading, x*70/100 == (x*70*5243) >> 19 for 8-bit x
	localparam logic [23:0] GRAY_COLOR  = 24'h808080;
	localparam logic [23:0] BLACK_COLOR = 24'h000000;
	localparam logic [18:0] SHADE_MUL   = 19'd367010;
	localparam int          SHADE_SHIFT = 19;
	localparam int          SHADE_PW    = 27;

	// item travelling down the pipeline
	typedef struct packed {
		logic        draw;     // visible wall pixel
		logic        wr_en;    // texel write inside the store
		logic        use_tex;
		logic        shade;
		logic        black;    // zero texture size
		logic [11:0] scol;
		logic [10:0] srow;
		logic [6:0]  tcol;     // write column or clamped draw column
		logic [5:0]  trow;
		logic [23:0] texel;
		logic [6:0]  th;       // texture height in use
	} twcs_item_t;

endpackage

// ===== rtl/core/twcs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcs_in_if / twcs_out_if
// Valid/ready channels carrying sampler requests and wall pixels.
// ----------------------------------------------------------------------------
interface twcs_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [11:0]        screen_col;
	logic [10:0]        screen_row;
	logic signed [15:0] wall_top;
	logic signed [15:0] wall_bottom;
	logic signed [7:0]  tex_col;
	logic [5:0]         tex_row;
	logic [23:0]        texel;
	logic               use_texture;
	logic               shade_side;

	modport source (
		output valid, func, screen_col, screen_row, wall_top, wall_bottom,
		output tex_col, tex_row, texel, use_texture, shade_side,
		input  ready
	);
	modport sink (
		input  valid, func, screen_col, screen_row, wall_top, wall_bottom,
		input  tex_col, tex_row, texel, use_texture, shade_side,
		output ready
	);
endinterface

interface twcs_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_col;
	logic [10:0] pixel_row;
	logic [23:0] pixel_color;

	modport source (output valid, pixel_col, pixel_row, pixel_color, input ready);
	modport sink (input valid, pixel_col, pixel_row, pixel_color, output ready);
endinterface

// ===== rtl/core/twcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcs_front
// Decodes a request: span and texture clamps, then row offset times height.
// ----------------------------------------------------------------------------
module twcs_front import twcs_pkg::*; #(
	parameter int TEX_MAX_W   = 64,
	parameter int TEX_MAX_H   = 64,
	parameter int MAX_FRAME_H = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	twcs_in_if.sink          din,
	input  logic [11:0]      frame_height,
	input  logic [12:0]      frame_width,
	input  logic [6:0]       tex_width,
	input  logic [6:0]       tex_height,
	output logic             v_s2,
	output twcs_item_t       item_s2,
	output logic [NUM_W-1:0] num_s2,
	output logic [DEN_W-1:0] den_s2
);

	logic               acc;
	logic [12:0]        fh;
	logic signed [17:0] top_x, bot_x, srow_x, fh_x, top_c, bot_c;
	logic               keep, wr_ok, black;
	logic [6:0]         tw, th, tc, tcol_c;
	twcs_item_t         item_d;

	logic               v_s1;
	twcs_item_t         item_s1;
	logic [10:0]        top_s1;
	logic [11:0]        bot_s1;
	logic [10:0]        diff;

	assign acc = din.valid & en;

	always_comb begin
		fh = ({1'b0, frame_height} > 13'(MAX_FRAME_H)) ? 13'(MAX_FRAME_H)
			: {1'b0, frame_height};
		fh_x   = signed'({5'b0, fh});
		top_x  = 18'(din.wall_top);
		bot_x  = 18'(din.wall_bottom);
		srow_x = signed'({7'b0, din.screen_row});
		top_c  = (top_x < 0) ? 18'sd0 : top_x;
		bot_c  = (bot_x >= fh_x) ? fh_x - 18'sd1 : bot_x;
		keep   = (srow_x >= top_c) && (srow_x <= bot_c)
			&& ({1'b0, din.screen_col} < frame_width);

		tw = ({2'b0, tex_width} > 9'(TEX_MAX_W)) ? 7'(TEX_MAX_W) : tex_width;
		th = ({2'b0, tex_height} > 9'(TEX_MAX_H)) ? 7'(TEX_MAX_H) : tex_height;
		tc = din.tex_col[7] ? 7'd0 : din.tex_col[6:0];
		tcol_c = (tc >= tw) ? tw - 7'd1 : tc;
		black  = (tw == 7'd0) || (th == 7'd0);

		wr_ok = !din.tex_col[7] && ({1'b0, din.tex_col} < 9'(TEX_MAX_W))
			&& ({3'b0, din.tex_row} < 9'(TEX_MAX_H));

		item_d.draw    = (din.func == FUNC_DRAW) && keep;
		item_d.wr_en   = (din.func == FUNC_WRITE) && wr_ok;
		item_d.use_tex = din.use_texture;
		item_d.shade   = din.shade_side;
		item_d.black   = black;
		item_d.scol    = din.screen_col;
		item_d.srow    = din.screen_row;
		item_d.tcol    = (din.func == FUNC_WRITE) ? din.tex_col[6:0] : tcol_c;
		item_d.trow    = din.tex_row;
		item_d.texel   = din.texel;
		item_d.th      = th;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && (item_d.draw || item_d.wr_en);
			v_s2 <= v_s1;
		end
	end

	// inside the span top <= row <= 2047 and bottom < 4096
	assign diff = item_s1.srow - top_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_d;
			top_s1  <= top_c[10:0];
			bot_s1  <= bot_c[11:0];
			item_s2 <= item_s1;
			num_s2  <= NUM_W'(diff) * NUM_W'(item_s1.th);
			den_s2  <= DEN_W'(bot_s1) - DEN_W'(top_s1) + DEN_W'(1);
		end
	end

endmodule

// ===== rtl/core/twcs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcs_div
// Pipelined restoring divider, one quotient bit per stage, item carried along.
// ----------------------------------------------------------------------------
module twcs_div import twcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  twcs_item_t       item_in,
	input  logic [NUM_W-1:0] num_in,
	input  logic [DEN_W-1:0] den_in,
	output logic             v_out,
	output twcs_item_t       item_out,
	output logic [QW-1:0]    q_out
);

	localparam int TW = NUM_W + 2;

	logic             v_s    [QW];
	twcs_item_t       item_s [QW];
	logic [NUM_W-1:0] rem_s  [QW];
	logic [QW-1:0]    q_s    [QW];
	logic [DEN_W-1:0] den_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stg
		localparam int B = QW - 1 - k;
		logic             v_k;
		twcs_item_t       item_k;
		logic [NUM_W-1:0] rem_k;
		logic [QW-1:0]    q_k;
		logic [DEN_W-1:0] den_k;
		logic [TW-1:0]    trial;

		if (k == 0) begin : g_first
			assign v_k    = v_in;
			assign item_k = item_in;
			assign rem_k  = num_in;
			assign q_k    = '0;
			assign den_k  = den_in;
		end else begin : g_next
			assign v_k    = v_s[k-1];
			assign item_k = item_s[k-1];
			assign rem_k  = rem_s[k-1];
			assign q_k    = q_s[k-1];
			assign den_k  = den_s[k-1];
		end

		// negative trial means the shifted divisor does not fit
		assign trial = {2'b0, rem_k} - (TW'(den_k) << B);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_k;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[k] <= item_k;
				den_s[k]  <= den_k;
				rem_s[k]  <= trial[TW-1] ? rem_k : trial[NUM_W-1:0];
				q_s[k]    <= {q_k[QW-2:0], !trial[TW-1]};
			end
		end
	end

	assign v_out    = v_s[QW-1];
	assign item_out = item_s[QW-1];
	assign q_out    = q_s[QW-1];

endmodule

// ===== rtl/core/twcs_tex.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcs_tex
// Texture store access, side shading and the output register.
// ----------------------------------------------------------------------------
module twcs_tex import twcs_pkg::*; #(
	parameter int TEX_MAX_W = 64,
	parameter int TEX_MAX_H = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          en,
	input  logic          v_in,
	input  twcs_item_t    item_in,
	input  logic [QW-1:0] q_in,
	twcs_out_if.source    dout
);

	localparam int DEPTH = TEX_MAX_W * TEX_MAX_H;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [23:0]         mem [DEPTH];
	logic [6:0]          ty, row;
	logic [16:0]         addr_full;
	logic [AW-1:0]       addr;

	logic                v_s10;
	twcs_item_t          item_s10;
	logic [23:0]         rdata_s10;

	logic [SHADE_PW-1:0] pr, pg, pb;
	logic [23:0]         shaded, color;
	logic                out_valid_q;
	logic [11:0]         out_col_q;
	logic [10:0]         out_row_q;
	logic [23:0]         out_color_q;

	// the whole pipeline moves when the output register is free or drained
	assign en = !out_valid_q || dout.ready;

	// quotient stays below the height, clamp kept for safety
	assign ty  = (q_in >= item_in.th) ? item_in.th - 7'd1 : q_in;
	assign row = item_in.wr_en ? {1'b0, item_in.trow} : ty;
	assign addr_full = 17'(row) * 17'(TEX_MAX_W) + 17'(item_in.tcol);
	assign addr = addr_full[AW-1:0];

	// single port, writes and reads stay in transaction order
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_in && item_in.wr_en) begin
				mem[addr] <= item_in.texel;
			end
			rdata_s10 <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s10 <= item_in;
		end
	end

	assign pr = SHADE_PW'(rdata_s10[23:16]) * SHADE_PW'(SHADE_MUL);
	assign pg = SHADE_PW'(rdata_s10[15:8]) * SHADE_PW'(SHADE_MUL);
	assign pb = SHADE_PW'(rdata_s10[7:0]) * SHADE_PW'(SHADE_MUL);
	assign shaded = {pr[SHADE_SHIFT+7:SHADE_SHIFT], pg[SHADE_SHIFT+7:SHADE_SHIFT],
		pb[SHADE_SHIFT+7:SHADE_SHIFT]};

	always_comb begin
		if (!item_s10.use_tex) begin
			color = GRAY_COLOR;
		end else if (item_s10.black) begin
			color = BLACK_COLOR;
		end else if (item_s10.shade) begin
			color = shaded;
		end else begin
			color = rdata_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s10       <= v_in;
			out_valid_q <= v_s10 && item_s10.draw;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_col_q   <= item_s10.scol;
			out_row_q   <= item_s10.srow;
			out_color_q <= color;
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.pixel_col   = out_col_q;
	assign dout.pixel_row   = out_row_q;
	assign dout.pixel_color = out_color_q;

endmodule

// ===== rtl/core/textured_wall_column_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// textured_wall_column_sampler
// Texture store plus wall pixel sampler for a column based renderer.
// ----------------------------------------------------------------------------
// din carries texel writes (func 0) and wall pixel draws (func 1); dout carries
// one pixel (column, row, RGB) for each draw that lands inside the clamped
// wall span and the frame. Writes and off-span draws give no transaction.
// The texture row comes from a 7-stage pipelined divider, one quotient bit per
// stage. Throughput is one transaction per cycle while dout is not stalled:
// the single-port texture store is read or written once per transaction, in
// order, so a draw always sees every earlier texel write.
// When dout is stalled the whole pipeline holds and din.ready drops; din.ready
// is high whenever the output register is empty or being taken.
// Reset clears the configuration to 480 x 640 frame and 64 x 64 texture and
// empties the pipeline; the texture store keeps whatever it held and must be
// written before it is sampled. Configuration writes through cfg_we/cfg_idx/
// cfg_data are taken every cycle and belong in idle periods.
// ----------------------------------------------------------------------------
module textured_wall_column_sampler import twcs_pkg::*; #(
	parameter int TEX_MAX_W   = 64,
	parameter int TEX_MAX_H   = 64,
	parameter int MAX_FRAME_H = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	twcs_in_if.sink              din,
	twcs_out_if.source           dout,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [11:0]      frame_height_q;
	logic [12:0]      frame_width_q;
	logic [6:0]       tex_width_q;
	logic [6:0]       tex_height_q;

	logic             en;
	logic             v_s2;
	twcs_item_t       item_s2;
	logic [NUM_W-1:0] num_s2;
	logic [DEN_W-1:0] den_s2;
	logic             v_div;
	twcs_item_t       item_div;
	logic [QW-1:0]    q_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_height_q <= FRAME_H_RST;
			frame_width_q  <= FRAME_W_RST;
			tex_width_q    <= TEX_W_RST;
			tex_height_q   <= TEX_H_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_FRAME_H: frame_height_q <= cfg_data[11:0];
				REG_FRAME_W: frame_width_q  <= cfg_data[12:0];
				REG_TEX_W:   tex_width_q    <= cfg_data[6:0];
				REG_TEX_H:   tex_height_q   <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign din.ready = en;

	twcs_front #(
		.TEX_MAX_W   (TEX_MAX_W),
		.TEX_MAX_H   (TEX_MAX_H),
		.MAX_FRAME_H (MAX_FRAME_H)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.din          (din),
		.frame_height (frame_height_q),
		.frame_width  (frame_width_q),
		.tex_width    (tex_width_q),
		.tex_height   (tex_height_q),
		.v_s2         (v_s2),
		.item_s2      (item_s2),
		.num_s2       (num_s2),
		.den_s2       (den_s2)
	);

	twcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s2),
		.item_in  (item_s2),
		.num_in   (num_s2),
		.den_in   (den_s2),
		.v_out    (v_div),
		.item_out (item_div),
		.q_out    (q_div)
	);

	twcs_tex #(
		.TEX_MAX_W (TEX_MAX_W),
		.TEX_MAX_H (TEX_MAX_H)
	) u_tex (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_div),
		.item_in (item_div),
		.q_in    (q_div),
		.dout    (dout)
	);

endmodule

// ===== rtl/core/twcs_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcs_chk
// Port level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module twcs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] out_col,
	input logic [10:0] out_row,
	input logic [23:0] out_color
);

	// a stalled pixel stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_col)
			&& $stable(out_row) && $stable(out_color))
		else $error("stalled pixel changed");

	// input side only stalls while a finished pixel waits
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output register state");

	// nothing comes out while in reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("pixel shown during reset");

	// a taken pixel frees the way for new transactions
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input blocked while output drains");

endmodule

bind textured_wall_column_sampler twcs_chk u_twcs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_col   (dout.pixel_col),
	.out_row   (dout.pixel_row),
	.out_color (dout.pixel_color)
);
